/* design/gsoa_pkg.sv */
`timescale 1ns / 1ps

package gsoa_pkg;

    localparam int PosW   = 16;            // position / obstacle fields
    localparam int TrigW  = 16;            // Q2.14 heading cos / sin
    localparam int DiffW  = PosW + 1;      // target minus pose
    localparam int LocW   = 34;            // rotated vector, squared distance
    localparam int MulAW  = LocW + 1;      // shared multiplier, A side
    localparam int MulBW  = 18;            // shared multiplier, B side
    localparam int ProdW  = MulAW + MulBW;
    localparam int SlopeFrac = 14;

    localparam logic signed [MulBW-1:0] SLOPE_AHEAD = 18'sd1644;  // tan 0.1
    localparam logic signed [MulBW-1:0] SLOPE_OFF   = 18'sd3321;  // tan 0.2

    localparam logic signed [PosW-1:0] NO_OBSTACLE = 16'sd32767;
    localparam logic signed [PosW-1:0] NEAR_MM     = 16'sd500;
    localparam logic signed [PosW-1:0] CLEAR_MM    = 16'sd750;
    localparam logic signed [LocW-1:0] ARRIVE_SQ   = 34'sd10000;
    localparam logic signed [LocW-1:0] LEAVE_SQ    = 34'sd40000;
    localparam logic signed [DiffW-1:0] FAR_AXIS   = 17'sd1024;

    // configuration register indexes
    localparam logic [2:0] REG_TA_X   = 3'd0;
    localparam logic [2:0] REG_TA_Y   = 3'd1;
    localparam logic [2:0] REG_TB_X   = 3'd2;
    localparam logic [2:0] REG_TB_Y   = 3'd3;
    localparam logic [2:0] REG_CRUISE = 3'd4;
    localparam logic [2:0] REG_TURN   = 3'd5;
    localparam logic [2:0] REG_AVOID  = 3'd6;
    localparam logic [2:0] REG_CORR   = 3'd7;

    localparam logic OP_OBSTACLE = 1'b0;
    localparam logic OP_TICK     = 1'b1;

    typedef enum logic [2:0] {
        MODE_TURN    = 3'd0,
        MODE_FORWARD = 3'd1,
        MODE_SEARCH  = 3'd2,
        MODE_AVOID   = 3'd3,
        MODE_STOP    = 3'd4
    } mode_t;

    // tick sequencer: each step from SEQ_LX0 to SEQ_SO feeds the shared multiplier once
    typedef enum logic [3:0] {
        SEQ_IDLE,
        SEQ_LX0,
        SEQ_LX1,
        SEQ_LY0,
        SEQ_LY1,
        SEQ_D0,
        SEQ_D1,
        SEQ_SA,
        SEQ_SO,
        SEQ_FIN
    } seq_t;

endpackage

/* design/gsoa_mul.sv */
`timescale 1ns / 1ps

// Shared signed multiplier, product registered.
module gsoa_mul
    import gsoa_pkg::*;
(
    input  logic                    aclk,
    input  logic signed [MulAW-1:0] op_a,
    input  logic signed [MulBW-1:0] op_b,
    output logic signed [ProdW-1:0] prod
);

    logic signed [ProdW-1:0] prod_reg;

    always_ff @(posedge aclk) begin
        prod_reg <= op_a * op_b;
    end

    assign prod = prod_reg;

endmodule

/* design/goal_seek_obstacle_avoid_fsm.sv */
`timescale 1ns / 1ps
// Obstacle beat: handled in the idle state; the next beat may follow at once while the result slot is free.
// Tick beat: 8 multiplier passes on one shared 35x18 multiplier, then a decision
// step that writes the result; one tick in flight at a time, the next beat is
// taken only after the sequencer is back in idle.
// Reset (aresetn low, synchronous): paused, Turn mode, target 0, no obstacle,
// goal not latched, configuration back to defaults, no result pending.
module goal_seek_obstacle_avoid_fsm
    import gsoa_pkg::*;
(
    input  logic                    aclk,
    input  logic                    aresetn,

    input  logic                    cfg_valid,
    output logic                    cfg_ready,
    input  logic [2:0]              cfg_index,
    input  logic [15:0]             cfg_data,

    input  logic                    s_valid,
    output logic                    s_ready,
    input  logic                    s_operation,
    input  logic signed [PosW-1:0]  s_obstacle_x,
    input  logic signed [PosW-1:0]  s_obstacle_y,
    input  logic signed [PosW-1:0]  s_pose_x,
    input  logic signed [PosW-1:0]  s_pose_y,
    input  logic signed [TrigW-1:0] s_heading_cos,
    input  logic signed [TrigW-1:0] s_heading_sin,
    input  logic [31:0]             s_time_ms,
    input  logic                    s_key_pressed,
    input  logic                    s_key_is_run,

    output logic                    m_valid,
    input  logic                    m_ready,
    output logic [9:0]              m_speed,
    output logic signed [11:0]      m_turn,
    output logic                    m_is_paused,
    output logic [2:0]              m_mode,
    output logic                    m_target_number,
    output logic                    m_goal_reached,
    output logic [31:0]             m_goal_time_ms
);

    // ------------------------------------------------------------------
    // configuration registers; always writable
    // ------------------------------------------------------------------
    logic signed [PosW-1:0] ta_x_reg, ta_y_reg, tb_x_reg, tb_y_reg;
    logic [9:0]             cruise_reg;
    logic [10:0]            turn_rate_reg;
    logic [15:0]            avoid_ms_reg;
    logic [10:0]            corr_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ta_x_reg      <= 16'sd1000;
            ta_y_reg      <= 16'sd3500;
            tb_x_reg      <= 16'sd2000;
            tb_y_reg      <= 16'sd0;
            cruise_reg    <= 10'd200;
            turn_rate_reg <= 11'd500;
            avoid_ms_reg  <= 16'd4000;
            corr_reg      <= 11'd300;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                REG_TA_X:   ta_x_reg      <= cfg_data;
                REG_TA_Y:   ta_y_reg      <= cfg_data;
                REG_TB_X:   tb_x_reg      <= cfg_data;
                REG_TB_Y:   tb_y_reg      <= cfg_data;
                REG_CRUISE: cruise_reg    <= cfg_data[9:0];
                REG_TURN:   turn_rate_reg <= cfg_data[10:0];
                REG_AVOID:  avoid_ms_reg  <= cfg_data;
                REG_CORR:   corr_reg      <= cfg_data[10:0];
                default:    ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // navigator state
    // ------------------------------------------------------------------
    seq_t  seq_reg, seq_next;
    mode_t mode_reg, mode_next;
    logic  target_reg, target_next;
    logic  paused_reg, paused_next;
    logic  search_left_reg, search_left_next;
    logic  goal_valid_reg, goal_valid_next;
    logic [31:0] avoid_start_reg, avoid_start_next;
    logic [31:0] goal_stamp_reg, goal_stamp_next;
    logic signed [PosW-1:0] near_fwd_reg, near_fwd_next;
    logic signed [PosW-1:0] near_lat_reg, near_lat_next;

    // tick operands, captured at accept
    logic signed [DiffW-1:0] dx_reg, dx_next;
    logic signed [DiffW-1:0] dy_reg, dy_next;
    logic signed [TrigW-1:0] cos_reg, cos_next;
    logic signed [TrigW-1:0] sin_reg, sin_next;
    logic [31:0]             now_reg, now_next;

    // intermediate results of the multiply sequence
    logic signed [LocW-1:0] acc_reg, acc_next;
    logic signed [LocW-1:0] lx_reg, lx_next;
    logic signed [LocW-1:0] ly_reg, ly_next;
    logic signed [LocW-1:0] d2_reg, d2_next;
    logic                   ahead_cmp_reg, ahead_cmp_next;

    // result holding register
    logic        m_valid_reg, m_valid_next;
    logic [9:0]  m_speed_reg, m_speed_next;
    logic signed [11:0] m_turn_reg, m_turn_next;
    logic        m_paused_reg, m_paused_next;
    logic [2:0]  m_mode_reg, m_mode_next;
    logic        m_target_reg, m_target_next;
    logic        m_goal_reg, m_goal_next;
    logic [31:0] m_goal_time_reg, m_goal_time_next;

    logic s_fire;
    logic is_idle;

    assign is_idle = (seq_reg == SEQ_IDLE);
    // the only result slot must be free (or freeing) before any beat is accepted
    assign s_ready = is_idle && (!m_valid_reg || m_ready);
    assign s_fire  = s_valid && s_ready;

    // ------------------------------------------------------------------
    // shared multiplier
    // ------------------------------------------------------------------
    logic signed [MulAW-1:0] mul_a;
    logic signed [MulBW-1:0] mul_b;
    logic signed [ProdW-1:0] prod;

    gsoa_mul u_mul (
        .aclk (aclk),
        .op_a (mul_a),
        .op_b (mul_b),
        .prod (prod)
    );

    logic signed [MulAW-1:0] dx_a, dy_a, ax_a;
    logic signed [MulBW-1:0] dx_b, dy_b, cos_b, sin_b;
    logic [LocW-1:0]         ax, ay;
    logic [ProdW-1:0]        ay_scaled;

    assign dx_a  = MulAW'(dx_reg);
    assign dy_a  = MulAW'(dy_reg);
    assign dx_b  = MulBW'(dx_reg);
    assign dy_b  = MulBW'(dy_reg);
    assign cos_b = MulBW'(cos_reg);
    assign sin_b = MulBW'(sin_reg);
    assign ax    = lx_reg[LocW-1] ? LocW'(-lx_reg) : LocW'(lx_reg);
    assign ay    = ly_reg[LocW-1] ? LocW'(-ly_reg) : LocW'(ly_reg);
    assign ax_a  = $signed({1'b0, ax});
    // |ly| * 2^14, compared against slope * |lx|
    assign ay_scaled = ProdW'({ay, {SlopeFrac{1'b0}}});

    // ------------------------------------------------------------------
    // sequencer: next state
    // ------------------------------------------------------------------
    always_comb begin
        seq_next = seq_reg;
        unique case (seq_reg)
            SEQ_IDLE: if (s_fire && s_operation == OP_TICK) seq_next = SEQ_LX0;
            SEQ_LX0:  seq_next = SEQ_LX1;
            SEQ_LX1:  seq_next = SEQ_LY0;
            SEQ_LY0:  seq_next = SEQ_LY1;
            SEQ_LY1:  seq_next = SEQ_D0;
            SEQ_D0:   seq_next = SEQ_D1;
            SEQ_D1:   seq_next = SEQ_SA;
            SEQ_SA:   seq_next = SEQ_SO;
            SEQ_SO:   seq_next = SEQ_FIN;
            SEQ_FIN:  seq_next = SEQ_IDLE;
            default:  seq_next = SEQ_IDLE;
        endcase
    end

    // ------------------------------------------------------------------
    // decision terms used in the final step
    // ------------------------------------------------------------------
    logic far_axis, far_leave, near_arrive;
    logic both_zero, lx_pos, ahead, off_axis, to_left;
    logic obst_near, obst_clear, avoid_done;
    logic [31:0] avoid_elapsed;
    logic signed [DiffW:0] oy_abs;

    assign far_axis = (dx_reg >= FAR_AXIS) || (dx_reg <= -FAR_AXIS)
                   || (dy_reg >= FAR_AXIS) || (dy_reg <= -FAR_AXIS);
    assign far_leave   = far_axis || (d2_reg > LEAVE_SQ);
    assign near_arrive = !far_axis && (d2_reg < ARRIVE_SQ);

    assign both_zero = (lx_reg == '0) && (ly_reg == '0);
    assign lx_pos    = (lx_reg > 0);
    assign ahead     = both_zero || (lx_pos && ahead_cmp_reg);
    // off axis unless inside the tan 0.2 cone; prod holds 3321*|lx| here
    assign off_axis  = !both_zero && (!lx_pos || (ay_scaled > $unsigned(prod)));
    assign to_left   = (ly_reg > 0) || ((ly_reg == '0) && (lx_reg < 0));

    assign obst_near     = (near_fwd_reg < NEAR_MM);
    assign obst_clear    = (near_fwd_reg > CLEAR_MM);
    assign avoid_elapsed = now_reg - avoid_start_reg;
    assign avoid_done    = (avoid_elapsed > {16'd0, avoid_ms_reg});

    assign oy_abs = s_obstacle_y[PosW-1] ? -(DiffW+1)'(s_obstacle_y)
                                         : (DiffW+1)'(s_obstacle_y);

    // ------------------------------------------------------------------
    // datapath and outputs
    // ------------------------------------------------------------------
    always_comb begin
        logic signed [PosW-1:0] tx, ty;

        mode_next        = mode_reg;
        target_next      = target_reg;
        paused_next      = paused_reg;
        search_left_next = search_left_reg;
        goal_valid_next  = goal_valid_reg;
        avoid_start_next = avoid_start_reg;
        goal_stamp_next  = goal_stamp_reg;
        near_fwd_next    = near_fwd_reg;
        near_lat_next    = near_lat_reg;
        dx_next          = dx_reg;
        dy_next          = dy_reg;
        cos_next         = cos_reg;
        sin_next         = sin_reg;
        now_next         = now_reg;
        acc_next         = acc_reg;
        lx_next          = lx_reg;
        ly_next          = ly_reg;
        d2_next          = d2_reg;
        ahead_cmp_next   = ahead_cmp_reg;
        mul_a            = dx_a;
        mul_b            = cos_b;

        m_valid_next     = m_valid_reg && !m_ready;
        m_speed_next     = m_speed_reg;
        m_turn_next      = m_turn_reg;
        m_paused_next    = m_paused_reg;
        m_mode_next      = m_mode_reg;
        m_target_next    = m_target_reg;
        m_goal_next      = m_goal_reg;
        m_goal_time_next = m_goal_time_reg;

        tx = target_reg ? tb_x_reg : ta_x_reg;
        ty = target_reg ? tb_y_reg : ta_y_reg;

        unique case (seq_reg)
            SEQ_IDLE: begin
                if (s_fire) begin
                    if (s_operation == OP_OBSTACLE) begin
                        // keep the closest point inside the corridor
                        if (oy_abs < $signed({7'd0, corr_reg})
                                && s_obstacle_x < near_fwd_reg) begin
                            near_fwd_next = s_obstacle_x;
                            near_lat_next = s_obstacle_y;
                        end
                    end else begin
                        if (s_key_pressed) begin
                            paused_next = !(paused_reg && s_key_is_run);
                        end
                        dx_next  = DiffW'(tx) - DiffW'(s_pose_x);
                        dy_next  = DiffW'(ty) - DiffW'(s_pose_y);
                        cos_next = s_heading_cos;
                        sin_next = s_heading_sin;
                        now_next = s_time_ms;
                    end
                end
            end
            SEQ_LX0: begin
                mul_a = dx_a;
                mul_b = cos_b;
            end
            SEQ_LX1: begin
                mul_a    = dy_a;
                mul_b    = sin_b;
                acc_next = LocW'(prod);
            end
            SEQ_LY0: begin
                mul_a   = dy_a;
                mul_b   = cos_b;
                lx_next = acc_reg + LocW'(prod);
            end
            SEQ_LY1: begin
                mul_a    = dx_a;
                mul_b    = sin_b;
                acc_next = LocW'(prod);
            end
            SEQ_D0: begin
                mul_a   = dx_a;
                mul_b   = dx_b;
                ly_next = acc_reg - LocW'(prod);
            end
            SEQ_D1: begin
                mul_a    = dy_a;
                mul_b    = dy_b;
                acc_next = LocW'(prod);
            end
            SEQ_SA: begin
                mul_a   = ax_a;
                mul_b   = SLOPE_AHEAD;
                d2_next = acc_reg + LocW'(prod);
            end
            SEQ_SO: begin
                mul_a          = ax_a;
                mul_b          = SLOPE_OFF;
                ahead_cmp_next = (ay_scaled < $unsigned(prod));
            end
            SEQ_FIN: begin
                m_speed_next = '0;
                m_turn_next  = '0;
                if (!paused_reg) begin
                    unique case (mode_reg)
                        MODE_STOP:    if (far_leave) mode_next = MODE_TURN;
                        MODE_TURN:    if (ahead) mode_next = MODE_FORWARD;
                        MODE_FORWARD: begin
                            if (near_arrive) begin
                                mode_next = MODE_STOP;
                            end else if (off_axis) begin
                                mode_next = MODE_TURN;
                            end else if (obst_near) begin
                                mode_next        = MODE_SEARCH;
                                search_left_next = !(near_lat_reg > 0);
                            end
                        end
                        MODE_SEARCH: begin
                            if (obst_clear) begin
                                mode_next        = MODE_AVOID;
                                avoid_start_next = now_reg;
                            end
                        end
                        MODE_AVOID: begin
                            if (avoid_done) begin
                                mode_next = MODE_TURN;
                            end else if (obst_near) begin
                                mode_next        = MODE_SEARCH;
                                search_left_next = !(near_lat_reg > 0);
                            end
                        end
                        default: ;
                    endcase

                    unique case (mode_next)
                        MODE_FORWARD, MODE_AVOID: m_speed_next = cruise_reg;
                        MODE_TURN: begin
                            m_turn_next = to_left ? $signed({1'b0, turn_rate_reg})
                                                  : -$signed({1'b0, turn_rate_reg});
                        end
                        MODE_SEARCH: begin
                            m_turn_next = search_left_next
                                        ? $signed({1'b0, turn_rate_reg})
                                        : -$signed({1'b0, turn_rate_reg});
                        end
                        MODE_STOP: begin
                            if (!target_reg) begin
                                target_next = 1'b1;
                            end else if (!goal_valid_reg) begin
                                goal_stamp_next = now_reg;
                                goal_valid_next = 1'b1;
                            end
                        end
                        default: ;
                    endcase
                end

                // every tick forgets the obstacle picture
                near_fwd_next = NO_OBSTACLE;
                near_lat_next = '0;

                m_valid_next     = 1'b1;
                m_paused_next    = paused_reg;
                m_mode_next      = mode_next;
                m_target_next    = target_next;
                m_goal_next      = goal_valid_next;
                m_goal_time_next = goal_stamp_next;
            end
            default: ;
        endcase
    end

    // ------------------------------------------------------------------
    // registers
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seq_reg         <= SEQ_IDLE;
            mode_reg        <= MODE_TURN;
            target_reg      <= 1'b0;
            paused_reg      <= 1'b1;
            search_left_reg <= 1'b0;
            goal_valid_reg  <= 1'b0;
            avoid_start_reg <= '0;
            goal_stamp_reg  <= '0;
            near_fwd_reg    <= NO_OBSTACLE;
            near_lat_reg    <= '0;
            m_valid_reg     <= 1'b0;
        end else begin
            seq_reg         <= seq_next;
            mode_reg        <= mode_next;
            target_reg      <= target_next;
            paused_reg      <= paused_next;
            search_left_reg <= search_left_next;
            goal_valid_reg  <= goal_valid_next;
            avoid_start_reg <= avoid_start_next;
            goal_stamp_reg  <= goal_stamp_next;
            near_fwd_reg    <= near_fwd_next;
            near_lat_reg    <= near_lat_next;
            m_valid_reg     <= m_valid_next;
        end
    end

    // payload, no reset
    always_ff @(posedge aclk) begin
        dx_reg          <= dx_next;
        dy_reg          <= dy_next;
        cos_reg         <= cos_next;
        sin_reg         <= sin_next;
        now_reg         <= now_next;
        acc_reg         <= acc_next;
        lx_reg          <= lx_next;
        ly_reg          <= ly_next;
        d2_reg          <= d2_next;
        ahead_cmp_reg   <= ahead_cmp_next;
        m_speed_reg     <= m_speed_next;
        m_turn_reg      <= m_turn_next;
        m_paused_reg    <= m_paused_next;
        m_mode_reg      <= m_mode_next;
        m_target_reg    <= m_target_next;
        m_goal_reg      <= m_goal_next;
        m_goal_time_reg <= m_goal_time_next;
    end

    assign m_valid         = m_valid_reg;
    assign m_speed         = m_speed_reg;
    assign m_turn          = m_turn_reg;
    assign m_is_paused     = m_paused_reg;
    assign m_mode          = m_mode_reg;
    assign m_target_number = m_target_reg;
    assign m_goal_reached  = m_goal_reg;
    assign m_goal_time_ms  = m_goal_time_reg;

endmodule
